@@ hdl/rpb_pkg.sv @@
// Shared types and constants for the RGBA8 pixel blend pipeline.
// No dependencies; imported by every module under hdl/.
package rpb_pkg;

    // blend_mode register codes; the unused code behaves as alpha over
    localparam logic [1:0] MODE_OVER  = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_ERASE = 2'd2;

    // Effective alpha is a numerator over DEN = 255 * 32768
    localparam int DEN_W  = 23;
    localparam int PROD_W = 31;
    localparam int SUM_W  = 32;
    localparam int Q15_SH = 15;

    localparam logic [DEN_W-1:0]  DEN_VAL  = 23'd8355840;
    localparam logic [DEN_W-1:0]  HALF_DEN = 23'd4177920;
    localparam logic [PROD_W-1:0] TOP_NUM  = 31'd2130739200;  // 255 * DEN
    // floor(t / 255) == (t * 0x8081) >> 23 for every 16-bit t
    localparam logic [15:0]       RECIP_255 = 16'h8081;
    localparam int                RECIP_SH  = 23;

    typedef struct packed {
        logic [7:0]  dest_red;
        logic [7:0]  dest_green;
        logic [7:0]  dest_blue;
        logic [7:0]  dest_alpha;
        logic [7:0]  src_red;
        logic [7:0]  src_green;
        logic [7:0]  src_blue;
        logic [7:0]  src_alpha;
        logic [15:0] coverage;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       written;
    } out_item_t;

    // Load enables of the six pipeline stages
    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic st4;
        logic st5;
        logic st6;
    } stage_en_t;

endpackage

@@ hdl/rpb_alpha.sv @@
// Effective alpha stages: source alpha times coverage, clamped to one.
// Depends on rpb_pkg. Occupies pipeline stages 1 and 2.
module rpb_alpha import rpb_pkg::*; (
    input  logic             aclk,
    input  stage_en_t        en,
    input  logic [7:0]       src_alpha,
    input  logic [15:0]      coverage,
    output logic [DEN_W-1:0] alpha,
    output logic [DEN_W-1:0] inv_alpha
);

    logic [DEN_W:0]   prod_reg;
    logic [DEN_W:0]   prod_next;
    logic [DEN_W-1:0] alpha_reg;
    logic [DEN_W-1:0] alpha_next;
    logic [DEN_W-1:0] inv_reg;
    logic [DEN_W-1:0] inv_next;

    assign prod_next  = {16'd0, src_alpha} * {8'd0, coverage};
    assign alpha_next = (prod_reg > {1'b0, DEN_VAL}) ? DEN_VAL : prod_reg[DEN_W-1:0];
    assign inv_next   = DEN_VAL - alpha_next;

    always_ff @(posedge aclk) begin
        if (en.st1) begin
            prod_reg <= prod_next;
        end
        if (en.st2) begin
            alpha_reg <= alpha_next;
            inv_reg   <= inv_next;
        end
    end

    assign alpha     = alpha_reg;
    assign inv_alpha = inv_reg;

endmodule

@@ hdl/rpb_chan.sv @@
// One channel of the blend: two products, sum, clamp, round to unorm8.
// Depends on rpb_pkg. Occupies pipeline stages 3, 4 and 5.
module rpb_chan import rpb_pkg::*; (
    input  logic             aclk,
    input  stage_en_t        en,
    input  logic             add_mode,
    input  logic [7:0]       src_op,
    input  logic [7:0]       dst,
    input  logic [DEN_W-1:0] alpha,
    input  logic [DEN_W-1:0] inv_alpha,
    output logic [7:0]       result
);

    logic [PROD_W-1:0] src_prod_reg;
    logic [PROD_W-1:0] src_prod_next;
    logic [PROD_W-1:0] dst_prod_reg;
    logic [PROD_W-1:0] dst_prod_next;
    logic [DEN_W-1:0]  dst_scale;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] clamped;
    logic [PROD_W-1:0] rounded;
    logic [15:0]       quo_in_reg;
    logic [15:0]       quo_in_next;
    logic [SUM_W-1:0]  recip_prod;
    logic [7:0]        q_reg;
    logic [7:0]        q_next;

    // add mode keeps the destination at full weight
    assign dst_scale     = add_mode ? DEN_VAL : inv_alpha;
    assign src_prod_next = {{(PROD_W-8){1'b0}}, src_op} * {{(PROD_W-DEN_W){1'b0}}, alpha};
    assign dst_prod_next = {{(PROD_W-8){1'b0}}, dst} * {{(PROD_W-DEN_W){1'b0}}, dst_scale};

    assign sum         = {1'b0, src_prod_reg} + {1'b0, dst_prod_reg};
    assign clamped     = (sum > {1'b0, TOP_NUM}) ? TOP_NUM : sum[PROD_W-1:0];
    assign rounded     = clamped + {{(PROD_W-DEN_W){1'b0}}, HALF_DEN};
    assign quo_in_next = rounded[PROD_W-1:Q15_SH];

    // divide by 255 through the reciprocal
    assign recip_prod = {16'd0, quo_in_reg} * {16'd0, RECIP_255};
    assign q_next     = recip_prod[RECIP_SH+7:RECIP_SH];

    always_ff @(posedge aclk) begin
        if (en.st3) begin
            src_prod_reg <= src_prod_next;
            dst_prod_reg <= dst_prod_next;
        end
        if (en.st4) begin
            quo_in_reg <= quo_in_next;
        end
        if (en.st5) begin
            q_reg <= q_next;
        end
    end

    assign result = q_reg;

endmodule

@@ hdl/rgba_pixel_blend_core.sv @@
// RGBA8 pixel blend (over / add / erase) with a six-stage pipeline.
// Depends on rpb_pkg, rpb_alpha and rpb_chan.
//
// Blends one straight-alpha source colour into one RGBA8 destination pixel
// per transaction. Effective alpha is src_alpha times Q1.15 coverage, clamped
// to one; cfg_blend_mode picks alpha over (0), additive (1) or erase (2), the
// unused code acting as over. Outside add mode a zero alpha passes the pixel
// through with written low. One pixel is accepted per clock unless a stalled
// output has filled every stage; the six stages are alpha
// product, alpha clamp, channel products, sum with clamp and rounding, divide
// by 255, and the output register. Each stage has its own valid bit and loads
// whenever it is empty or the next stage moves, so a stalled output still lets
// upstream bubbles fill. Write cfg_blend_mode only while no pixel is in flight.
module rgba_pixel_blend_core import rpb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_blend_mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    localparam int NUM_ST = 6;

    logic [1:0]        mode_reg;
    logic [NUM_ST:1]   valid_reg;
    logic [NUM_ST:1]   valid_next;
    logic [NUM_ST:1]   load;
    stage_en_t         en;
    in_item_t          item_reg [1:5];
    out_item_t         out_reg;
    out_item_t         out_next;
    logic [DEN_W-1:0]  alpha;
    logic [DEN_W-1:0]  inv_alpha;
    logic              add_mode;
    logic              erase_mode;
    logic [7:0]        col_op;
    logic [7:0]        alpha_op;
    logic [7:0]        q_red;
    logic [7:0]        q_green;
    logic [7:0]        q_blue;
    logic [7:0]        q_alpha;
    logic [7:0]        max_rg;
    logic [7:0]        max_ba;
    logic              zero_alpha;

    assign cfg_ready  = 1'b1;
    assign add_mode   = (mode_reg == MODE_ADD);
    assign erase_mode = (mode_reg == MODE_ERASE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_OVER;
        end else if (cfg_valid) begin
            mode_reg <= cfg_blend_mode;
        end
    end

    // stage k loads when empty or when stage k+1 takes its contents
    always_comb begin
        load[NUM_ST] = !valid_reg[NUM_ST] || m_ready;
        for (int k = NUM_ST - 1; k >= 1; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign en = '{st1: load[1], st2: load[2], st3: load[3],
                  st4: load[4], st5: load[5], st6: load[6]};

    always_comb begin
        valid_next = valid_reg;
        if (load[1]) begin
            valid_next[1] = s_valid;
        end
        for (int k = 2; k <= NUM_ST; k++) begin
            if (load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            item_reg[1] <= s_data;
        end
        for (int k = 2; k <= 5; k++) begin
            if (load[k]) begin
                item_reg[k] <= item_reg[k-1];
            end
        end
        if (load[NUM_ST]) begin
            out_reg <= out_next;
        end
    end

    rpb_alpha u_alpha (
        .aclk      (aclk),
        .en        (en),
        .src_alpha (s_data.src_alpha),
        .coverage  (s_data.coverage),
        .alpha     (alpha),
        .inv_alpha (inv_alpha)
    );

    // source multiplicands: colour drops out in erase, alpha term is 255*a in over
    assign col_op   = erase_mode ? 8'd0 : 8'd0 | 8'd0;
    assign alpha_op = (add_mode || erase_mode) ? 8'd0 : 8'd255;

    rpb_chan u_red (
        .aclk      (aclk),
        .en        (en),
        .add_mode  (add_mode),
        .src_op    (erase_mode ? col_op : item_reg[2].src_red),
        .dst       (item_reg[2].dest_red),
        .alpha     (alpha),
        .inv_alpha (inv_alpha),
        .result    (q_red)
    );

    rpb_chan u_green (
        .aclk      (aclk),
        .en        (en),
        .add_mode  (add_mode),
        .src_op    (erase_mode ? col_op : item_reg[2].src_green),
        .dst       (item_reg[2].dest_green),
        .alpha     (alpha),
        .inv_alpha (inv_alpha),
        .result    (q_green)
    );

    rpb_chan u_blue (
        .aclk      (aclk),
        .en        (en),
        .add_mode  (add_mode),
        .src_op    (erase_mode ? col_op : item_reg[2].src_blue),
        .dst       (item_reg[2].dest_blue),
        .alpha     (alpha),
        .inv_alpha (inv_alpha),
        .result    (q_blue)
    );

    rpb_chan u_alpha_ch (
        .aclk      (aclk),
        .en        (en),
        .add_mode  (add_mode),
        .src_op    (alpha_op),
        .dst       (item_reg[2].dest_alpha),
        .alpha     (alpha),
        .inv_alpha (inv_alpha),
        .result    (q_alpha)
    );

    // add mode: alpha channel already holds dest_alpha, raise to brightest channel
    assign max_rg     = (q_red > q_green) ? q_red : q_green;
    assign max_ba     = (q_blue > q_alpha) ? q_blue : q_alpha;
    assign zero_alpha = (item_reg[5].src_alpha == 8'd0) || (item_reg[5].coverage == 16'd0);

    always_comb begin
        if (zero_alpha && !add_mode) begin
            out_next.out_red   = item_reg[5].dest_red;
            out_next.out_green = item_reg[5].dest_green;
            out_next.out_blue  = item_reg[5].dest_blue;
            out_next.out_alpha = item_reg[5].dest_alpha;
            out_next.written   = 1'b0;
        end else begin
            out_next.out_red   = q_red;
            out_next.out_green = q_green;
            out_next.out_blue  = q_blue;
            out_next.out_alpha = add_mode ? ((max_rg > max_ba) ? max_rg : max_ba) : q_alpha;
            out_next.written   = 1'b1;
        end
    end

    assign s_ready = load[1];
    assign m_valid = valid_reg[NUM_ST];
    assign m_data  = out_reg;

    // clamped alpha and its complement always sum to one
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[3] |-> ({1'b0, alpha} + {1'b0, inv_alpha} == {1'b0, DEN_VAL}))
        else $error("alpha and inverse alpha do not sum to one");

    // an unwritten result only leaves the block outside add mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.written) |-> (mode_reg != MODE_ADD))
        else $error("unwritten pixel produced in add mode");

    // an accepted transaction occupies the first stage on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[1])
        else $error("accepted transaction lost at stage 1");

    // a stalled output stage holds its result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)))
        else $error("stalled result changed");

endmodule
